/* hw/rtl/joystick_drive_ramp_controller_assert.svh */
// ----------------------------------------------------------------------------
// joystick_drive_ramp_controller_assert.svh
// Assertion macros for the drive ramp controller; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DRIVE_RAMP_CONTROLLER_ASSERT_SVH
`define JOYSTICK_DRIVE_RAMP_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define JDRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define JDRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define JDRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define JDRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hw/rtl/jdrc_pkg.sv */
// ----------------------------------------------------------------------------
// jdrc_pkg
// Shared types, codes and constants of the joystick drive ramp controller.
// ----------------------------------------------------------------------------
package jdrc_pkg;

   // Fraction bits of the fixed-point scaling
   localparam int FRAC_BITS = 15;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Input commands
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_JOY  = 2'd1;
   localparam logic [1:0] CMD_BUMP = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] REG_DEADZONE   = 3'd0;
   localparam logic [2:0] REG_ACCEL      = 3'd1;
   localparam logic [2:0] REG_DECEL      = 3'd2;
   localparam logic [2:0] REG_ANG_GAIN   = 3'd3;
   localparam logic [2:0] REG_SPEED_UNIT = 3'd4;
   localparam logic [2:0] REG_LEVELS_MAX = 3'd5;

   // Configuration reset values
   localparam logic [14:0] RST_DEADZONE   = 15'd4915;
   localparam logic [14:0] RST_ACCEL      = 15'd328;
   localparam logic [14:0] RST_DECEL      = 15'd328;
   localparam logic [15:0] RST_ANG_GAIN   = 16'd49152;
   localparam logic [14:0] RST_SPEED_UNIT = 15'd1638;
   localparam logic [3:0]  RST_LEVELS_MAX = 4'd10;

   // Goal code for cancel
   localparam logic [3:0] GOAL_CANCEL = 4'd8;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_VEL  = 2'd0,
      KIND_GOAL = 2'd1,
      KIND_HORN = 2'd2
   } kind_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      B_IDLE,
      B_UNIT,
      B_LIN,
      B_OUT
   } back_state_type;

   // Configuration register file
   typedef struct packed {
      logic [14:0] deadzone;
      logic [14:0] accel_step;
      logic [14:0] decel_step;
      logic [15:0] angular_gain;
      logic [14:0] speed_unit;
      logic [3:0]  speed_levels_max;
   } cfg_type;

   // One result to be carried out by the back end
   typedef struct packed {
      kind_type           kind;
      logic [3:0]         goal;
      logic               last;
      logic signed [15:0] speed;
      logic [3:0]         level;
      logic signed [15:0] turn;
   } desc_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* hw/rtl/jdrc_queue.sv */
// ----------------------------------------------------------------------------
// jdrc_queue
// Small FIFO of result descriptors between the front and the back end.
// ----------------------------------------------------------------------------
module jdrc_queue
   import jdrc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  desc_type  push_desc,
   input  logic      pop,
   output desc_type  head_desc,
   output qstat_type stat
);

   desc_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ff, wr_in;
   logic [QPTR_W-1:0]    rd_ff, rd_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = QCNT_W'(cnt_ff + 1'b1);
      end else if (!push && pop) begin
         cnt_in = QCNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store pushed descriptor
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_desc;
      end
   end

   assign head_desc  = mem_ff[rd_ff];
   assign stat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

/* hw/rtl/jdrc_front.sv */
// ----------------------------------------------------------------------------
// jdrc_front
// Accepts items, updates drive state and issues one descriptor per result.
// ----------------------------------------------------------------------------
module jdrc_front
   import jdrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic [8:0]         req_buttons,
   input  logic               req_bumper_pressed,
   input  qstat_type          q_stat,
   output logic               q_push,
   output desc_type           q_desc
);

   // Drive state
   logic signed [15:0] cur_ff, cur_in;
   logic signed [15:0] ts_ff, ts_in;
   logic signed [15:0] tt_ff, tt_in;
   logic               run_ff, run_in;
   logic               latch_ff, latch_in;
   logic [5:0]         held_ff, held_in;
   logic [3:0]         lvl_ff, lvl_in;

   // Pending results of the item at work:
   // bit 0 velocity, 1 power cancel, 2 stick cancel, 3..6 goals A..Y, 7 horn
   logic [7:0]         pend_ff, pend_in;
   logic signed [15:0] snap_speed_ff, snap_speed_in;
   logic [3:0]         snap_level_ff, snap_level_in;
   logic signed [15:0] snap_turn_ff, snap_turn_in;
   logic               shift_ff, shift_in;

   logic               acc;
   logic signed [15:0] c_tick;
   logic               outside;
   logic [7:0]         oh;

   assign req_stall = |pend_ff;
   assign acc       = req_valid && !req_stall;

   // Ramp current speed one tick toward the target
   always_comb begin
      logic signed [17:0] c18, ts18, a18, d18, s18, r18;
      c18  = 18'(cur_ff);
      ts18 = 18'(ts_ff);
      a18  = $signed({3'b000, cfg.accel_step});
      d18  = $signed({3'b000, cfg.decel_step});
      r18  = c18;
      s18  = c18;
      if (ts_ff == '0) begin
         if (c18 > 18'sd0) begin
            r18 = (c18 <= d18) ? 18'sd0 : c18 - d18;
         end else if (c18 < 18'sd0) begin
            r18 = (c18 >= -d18) ? 18'sd0 : c18 + d18;
         end
      end else if (c18 < ts18) begin
         s18 = c18 + a18;
         r18 = (s18 > ts18) ? ts18 : s18;
      end else if (c18 > ts18) begin
         s18 = c18 - a18;
         r18 = (s18 < ts18) ? ts18 : s18;
      end
      c_tick = r18[15:0];
   end

   // Classify the stick against the deadzone
   always_comb begin
      logic signed [16:0] x17, y17, dz17;
      x17     = 17'(req_axis_x);
      y17     = 17'(req_axis_y);
      dz17    = $signed({2'b00, cfg.deadzone});
      outside = (x17 > dz17) || (x17 < -dz17) || (y17 > dz17) || (y17 < -dz17);
   end

   // Next drive state and pending results
   always_comb begin
      logic       power;
      logic       latch_mid;
      logic [3:0] lvl_mid;
      cur_in        = cur_ff;
      ts_in         = ts_ff;
      tt_in         = tt_ff;
      run_in        = run_ff;
      latch_in      = latch_ff;
      held_in       = held_ff;
      lvl_in        = lvl_ff;
      snap_speed_in = snap_speed_ff;
      snap_level_in = snap_level_ff;
      snap_turn_in  = snap_turn_ff;
      shift_in      = shift_ff;
      power         = req_buttons[8];
      latch_mid     = latch_ff || power;
      lvl_mid       = lvl_ff;
      pend_in       = q_push ? (pend_ff & ~oh) : pend_ff;
      if (acc) begin
         pend_in = '0;
         case (req_command)
            CMD_TICK: begin
               if (run_ff) begin
                  cur_in        = c_tick;
                  snap_speed_in = c_tick;
                  snap_level_in = lvl_ff;
                  snap_turn_in  = tt_ff;
                  pend_in[0]    = 1'b1;
                  if (c_tick == '0 && ts_ff == '0 && tt_ff == '0) begin
                     run_in = 1'b0;
                  end
               end
            end
            CMD_JOY: begin
               snap_speed_in = '0;
               snap_turn_in  = '0;
               snap_level_in = lvl_ff;
               shift_in      = req_buttons[5];
               if (power) begin
                  run_in     = 1'b0;
                  cur_in     = '0;
                  pend_in[0] = 1'b1;
                  pend_in[1] = 1'b1;
               end
               latch_in = latch_mid;
               if (outside && !latch_mid) begin
                  tt_in      = req_axis_x;
                  ts_in      = req_axis_y;
                  pend_in[2] = 1'b1;
                  run_in     = 1'b1;
               end
               if (!outside) begin
                  tt_in    = '0;
                  ts_in    = '0;
                  latch_in = 1'b0;
               end
               pend_in[6:3] = req_buttons[3:0] & ~held_ff[3:0];
               pend_in[7]   = req_buttons[4];
               // Step the speed level: back lowers, start raises
               if (req_buttons[6] && !held_ff[4] && lvl_mid > 4'd1) begin
                  lvl_mid = lvl_mid - 4'd1;
               end
               if (req_buttons[7] && !held_ff[5] && lvl_mid < cfg.speed_levels_max) begin
                  lvl_mid = lvl_mid + 4'd1;
               end
               lvl_in  = lvl_mid;
               held_in = {req_buttons[7:6], req_buttons[3:0]};
            end
            CMD_BUMP: begin
               if (req_bumper_pressed) begin
                  latch_in = 1'b1;
                  run_in   = 1'b0;
                  cur_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Pick the lowest pending result and build its descriptor
   always_comb begin
      oh          = pend_ff & (~pend_ff + 8'd1);
      q_push      = (|pend_ff) && !q_stat.full;
      q_desc      = '0;
      q_desc.last = ((pend_ff & ~oh) == '0);
      if (oh[0]) begin
         q_desc.kind  = KIND_VEL;
         q_desc.speed = snap_speed_ff;
         q_desc.level = snap_level_ff;
         q_desc.turn  = snap_turn_ff;
      end else if (oh[1] || oh[2]) begin
         q_desc.kind = KIND_GOAL;
         q_desc.goal = GOAL_CANCEL;
      end else if (oh[3]) begin
         q_desc.kind = KIND_GOAL;
         q_desc.goal = {1'b0, shift_ff, 2'd0};
      end else if (oh[4]) begin
         q_desc.kind = KIND_GOAL;
         q_desc.goal = {1'b0, shift_ff, 2'd1};
      end else if (oh[5]) begin
         q_desc.kind = KIND_GOAL;
         q_desc.goal = {1'b0, shift_ff, 2'd2};
      end else if (oh[6]) begin
         q_desc.kind = KIND_GOAL;
         q_desc.goal = {1'b0, shift_ff, 2'd3};
      end else begin
         q_desc.kind = KIND_HORN;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         ts_ff    <= '0;
         tt_ff    <= '0;
         run_ff   <= 1'b1;
         latch_ff <= 1'b0;
         held_ff  <= '0;
         lvl_ff   <= RST_LEVELS_MAX;
         pend_ff  <= '0;
      end else begin
         cur_ff   <= cur_in;
         ts_ff    <= ts_in;
         tt_ff    <= tt_in;
         run_ff   <= run_in;
         latch_ff <= latch_in;
         held_ff  <= held_in;
         lvl_ff   <= lvl_in;
         pend_ff  <= pend_in;
      end
   end

   // Snapshot payload for the results of the item
   always_ff @(posedge clock) begin
      snap_speed_ff <= snap_speed_in;
      snap_level_ff <= snap_level_in;
      snap_turn_ff  <= snap_turn_in;
      shift_ff      <= shift_in;
   end

endmodule

/* hw/rtl/jdrc_back.sv */
// ----------------------------------------------------------------------------
// jdrc_back
// Pops descriptors, scales velocity commands and drives the result register.
// ----------------------------------------------------------------------------
module jdrc_back
   import jdrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  qstat_type          q_stat,
   input  desc_type           q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_linear_out,
   output logic signed [16:0] rsp_angular_out,
   output logic [3:0]         rsp_goal_code,
   output logic               rsp_last
);

   localparam logic [35:0]        HALF    = 36'(1) << (FRAC_BITS - 1);
   localparam logic signed [35:0] LIN_MAX = 36'sd32767;
   localparam logic signed [35:0] LIN_MIN = -36'sd32768;
   localparam logic signed [35:0] ANG_MAX = 36'sd65535;
   localparam logic signed [35:0] ANG_MIN = -36'sd65536;

   back_state_type     st_ff, st_in;
   desc_type           d_ff, d_in;
   logic [18:0]        unit_ff, unit_in;
   logic signed [32:0] angp_ff, angp_in;
   logic signed [35:0] linp_ff, linp_in;

   logic               valid_ff, valid_in;
   logic [1:0]         kind_ff, kind_in;
   logic signed [15:0] lin_ff, lin_in;
   logic signed [16:0] ang_ff, ang_in;
   logic [3:0]         goal_ff, goal_in;
   logic               last_ff, last_in;

   logic               out_free;
   logic               load_direct;
   logic               load_vel;

   // Round to nearest on the magnitude, ties away from zero
   function automatic logic signed [35:0] scale_round(input logic signed [35:0] p);
      logic [35:0] mag;
      logic [35:0] rm;
      mag         = p[35] ? 36'(-p) : 36'(p);
      rm          = (mag + HALF) >> FRAC_BITS;
      scale_round = p[35] ? -$signed(rm) : $signed(rm);
   endfunction

   assign out_free = !valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         B_IDLE: begin
            if (!q_stat.empty && out_free && q_head.kind == KIND_VEL) begin
               st_in = B_UNIT;
            end
         end
         B_UNIT: st_in = B_LIN;
         B_LIN:  st_in = B_OUT;
         B_OUT: begin
            if (out_free) begin
               st_in = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      q_pop       = 1'b0;
      load_direct = 1'b0;
      load_vel    = 1'b0;
      case (st_ff)
         B_IDLE: begin
            q_pop       = !q_stat.empty && out_free;
            load_direct = q_pop && (q_head.kind != KIND_VEL);
         end
         B_OUT: begin
            load_vel = out_free;
         end
         default: begin
         end
      endcase
   end

   // Multiply datapath: unit and turn first, then linear
   always_comb begin
      d_in    = q_pop ? q_head : d_ff;
      unit_in = 19'(d_ff.level) * 19'(cfg.speed_unit);
      angp_in = 33'(d_ff.turn) * 33'($signed({1'b0, cfg.angular_gain}));
      linp_in = 36'(d_ff.speed) * 36'($signed({1'b0, unit_ff}));
   end

   // Result register
   always_comb begin
      logic signed [35:0] lr;
      logic signed [35:0] ar;
      lr       = scale_round(linp_ff);
      ar       = scale_round(36'(angp_ff));
      valid_in = out_free ? 1'b0 : valid_ff;
      kind_in  = kind_ff;
      lin_in   = lin_ff;
      ang_in   = ang_ff;
      goal_in  = goal_ff;
      last_in  = last_ff;
      if (load_direct) begin
         valid_in = 1'b1;
         kind_in  = q_head.kind;
         lin_in   = '0;
         ang_in   = '0;
         goal_in  = q_head.goal;
         last_in  = q_head.last;
      end else if (load_vel) begin
         valid_in = 1'b1;
         kind_in  = KIND_VEL;
         goal_in  = '0;
         last_in  = d_ff.last;
         if (lr > LIN_MAX) begin
            lin_in = 16'sh7FFF;
         end else if (lr < LIN_MIN) begin
            lin_in = 16'sh8000;
         end else begin
            lin_in = lr[15:0];
         end
         if (ar > ANG_MAX) begin
            ang_in = 17'sh0FFFF;
         end else if (ar < ANG_MIN) begin
            ang_in = 17'sh10000;
         end else begin
            ang_in = ar[16:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      unit_ff <= unit_in;
      angp_ff <= angp_in;
      linp_ff <= linp_in;
      kind_ff <= kind_in;
      lin_ff  <= lin_in;
      ang_ff  <= ang_in;
      goal_ff <= goal_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_linear_out  = lin_ff;
   assign rsp_angular_out = ang_ff;
   assign rsp_goal_code   = goal_ff;
   assign rsp_last        = last_ff;

endmodule

/* hw/rtl/joystick_drive_ramp_controller.sv */
// Result path: a goal or horn result goes from the queue head into the result register;
//   a velocity result first passes the back end's unit, linear and rounding steps.
// Flow: the front takes no new item until all results of the last are queued; the back
//   pops nothing while a velocity result is in work or the output stalls (4-entry queue).
// Reset: synchronous, active high; control and configuration registers are reset.
// ----------------------------------------------------------------------------
// joystick_drive_ramp_controller
// Teleoperation drive controller with stick deadzone and speed slew limiting.
// ----------------------------------------------------------------------------
`include "joystick_drive_ramp_controller_assert.svh"

module joystick_drive_ramp_controller
   import jdrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Configuration port
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   // Input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic [8:0]         req_buttons,
   input  logic               req_bumper_pressed,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_linear_out,
   output logic signed [16:0] rsp_angular_out,
   output logic [3:0]         rsp_goal_code,
   output logic               rsp_last
);

   cfg_type   cfg_ff, cfg_in;
   qstat_type q_stat;
   logic      q_push;
   logic      q_pop;
   desc_type  q_desc;
   desc_type  q_head;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DEADZONE:   cfg_in.deadzone         = csr_wdata[14:0];
            REG_ACCEL:      cfg_in.accel_step       = csr_wdata[14:0];
            REG_DECEL:      cfg_in.decel_step       = csr_wdata[14:0];
            REG_ANG_GAIN:   cfg_in.angular_gain     = csr_wdata;
            REG_SPEED_UNIT: cfg_in.speed_unit       = csr_wdata[14:0];
            REG_LEVELS_MAX: cfg_in.speed_levels_max = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadzone         <= RST_DEADZONE;
         cfg_ff.accel_step       <= RST_ACCEL;
         cfg_ff.decel_step       <= RST_DECEL;
         cfg_ff.angular_gain     <= RST_ANG_GAIN;
         cfg_ff.speed_unit       <= RST_SPEED_UNIT;
         cfg_ff.speed_levels_max <= RST_LEVELS_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jdrc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_axis_x         (req_axis_x),
      .req_axis_y         (req_axis_y),
      .req_buttons        (req_buttons),
      .req_bumper_pressed (req_bumper_pressed),
      .q_stat             (q_stat),
      .q_push             (q_push),
      .q_desc             (q_desc)
   );

   jdrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .head_desc (q_head),
      .stat      (q_stat)
   );

   jdrc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_stat          (q_stat),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_linear_out  (rsp_linear_out),
      .rsp_angular_out (rsp_angular_out),
      .rsp_goal_code   (rsp_goal_code),
      .rsp_last        (rsp_last)
   );

   // Queue discipline and result sanity
   `JDRC_ASSERT_IMPLY(a_push_room, clock, reset, q_push, !q_stat.full, "push into full queue")
   `JDRC_ASSERT_IMPLY(a_pop_data, clock, reset, q_pop, !q_stat.empty, "pop from empty queue")
   `JDRC_ASSERT_NEXT(a_push_held, clock, reset, q_push, !q_stat.empty, "pushed entry lost")
   `JDRC_ASSERT_IMPLY(a_vel_goal, clock, reset, rsp_valid && (rsp_kind == KIND_VEL), rsp_goal_code == 4'd0, "velocity result with goal code")

endmodule
